// ----- hw/rtl/gpd_pkg.sv -----
// gpd_pkg: constants shared by the gyro packet deframer.
// No dependencies.
`timescale 1ns / 1ps

package gpd_pkg;

  localparam int unsigned ByteW = 8;
  localparam int unsigned WordW = 16;

  localparam logic [ByteW-1:0] HdrByte = 8'hFF;
  localparam logic [WordW-1:0] SumSeed = 16'hFFFF;

endpackage

// ----- hw/rtl/gyro_packet_deframer.sv -----
// Gyro packet deframer: header hunt, payload capture and checksum test.
// Depends on gpd_pkg.
//
// Usage:
//   Input channel (in_valid_i / in_ready_o / rx_byte_i) carries one received
//   link byte per transaction. The block hunts for two 0xFF header bytes; a
//   second byte other than 0xFF is dropped and the hunt restarts. The next
//   six bytes are payload (rate, angle, checksum, little-endian) regardless
//   of their value.
//   Output channel (out_valid_o / out_ready_i) carries one transaction per
//   packet: rate_centi_o, angle_centi_o and checksum_ok_o. Bad packets still
//   come out, with checksum_ok_o low; the receiver drops them.
//   Output timing: the result is registered and valid in the cycle after the
//   last payload byte is accepted. Throughput: one byte per cycle while
//   in_ready_o is high; a held result with out_ready_i low stalls input.
//   Reset: phase returns to header hunt and the output register empties.
//   Stall: a held result blocks input only while out_ready_i is low; the
//   result moves out and a new byte is taken in the same cycle otherwise.
`timescale 1ns / 1ps

module gyro_packet_deframer (
  input  logic                         clk_i,
  input  logic                         rst_ni,
  input  logic                         in_valid_i,
  output logic                         in_ready_o,
  input  logic [gpd_pkg::ByteW-1:0]    rx_byte_i,
  output logic                         out_valid_o,
  input  logic                         out_ready_i,
  output logic signed [gpd_pkg::WordW-1:0] rate_centi_o,
  output logic signed [gpd_pkg::WordW-1:0] angle_centi_o,
  output logic                         checksum_ok_o
);

  typedef enum logic [2:0] {
    PhHunt   = 3'd0,
    PhHdr2   = 3'd1,
    PhRateLo = 3'd2,
    PhRateHi = 3'd3,
    PhAngLo  = 3'd4,
    PhAngHi  = 3'd5,
    PhSumLo  = 3'd6,
    PhSumHi  = 3'd7
  } phase_e;

  phase_e phase_q, phase_d;

  logic [gpd_pkg::ByteW-1:0] rate_lo_q, rate_hi_q, ang_lo_q, ang_hi_q, sum_lo_q;

  logic                      out_valid_q, out_valid_d;
  logic [gpd_pkg::WordW-1:0] rate_q, angle_q;
  logic                      ok_q;

  logic                      in_fire;
  logic                      pkt_done;
  logic [gpd_pkg::WordW-1:0] rate_w, angle_w, sum_w, expect_w;

  assign in_ready_o = !out_valid_q || out_ready_i;
  assign in_fire    = in_valid_i && in_ready_o;
  assign pkt_done   = in_fire && (phase_q == PhSumHi);

  assign rate_w   = {rate_hi_q, rate_lo_q};
  assign angle_w  = {ang_hi_q, ang_lo_q};
  assign sum_w    = {rx_byte_i, sum_lo_q};
  assign expect_w = gpd_pkg::SumSeed + rate_w + angle_w;

  always_comb begin
    phase_d = phase_q;
    if (in_fire) begin
      unique case (phase_q)
        PhHunt:   phase_d = (rx_byte_i == gpd_pkg::HdrByte) ? PhHdr2 : PhHunt;
        // a bad second header byte is consumed, not retried as a first one
        PhHdr2:   phase_d = (rx_byte_i == gpd_pkg::HdrByte) ? PhRateLo : PhHunt;
        PhRateLo: phase_d = PhRateHi;
        PhRateHi: phase_d = PhAngLo;
        PhAngLo:  phase_d = PhAngHi;
        PhAngHi:  phase_d = PhSumLo;
        PhSumLo:  phase_d = PhSumHi;
        PhSumHi:  phase_d = PhHunt;
        default:  phase_d = PhHunt;
      endcase
    end
  end

  always_comb begin
    out_valid_d = out_valid_q;
    if (pkt_done) begin
      out_valid_d = 1'b1;
    end else if (out_ready_i) begin
      out_valid_d = 1'b0;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      phase_q     <= PhHunt;
      out_valid_q <= 1'b0;
    end else begin
      phase_q     <= phase_d;
      out_valid_q <= out_valid_d;
    end
  end

  // payload bytes are always written before they are read
  always_ff @(posedge clk_i) begin
    if (in_fire) begin
      if (phase_q == PhRateLo) rate_lo_q <= rx_byte_i;
      if (phase_q == PhRateHi) rate_hi_q <= rx_byte_i;
      if (phase_q == PhAngLo)  ang_lo_q  <= rx_byte_i;
      if (phase_q == PhAngHi)  ang_hi_q  <= rx_byte_i;
      if (phase_q == PhSumLo)  sum_lo_q  <= rx_byte_i;
    end
    if (pkt_done) begin
      rate_q  <= rate_w;
      angle_q <= angle_w;
      ok_q    <= (sum_w == expect_w);
    end
  end

  assign out_valid_o   = out_valid_q;
  assign rate_centi_o  = $signed(rate_q);
  assign angle_centi_o = $signed(angle_q);
  assign checksum_ok_o = ok_q;

endmodule

// ----- hw/rtl/gpd_checker.sv -----
// gpd_checker: port-level checks for gyro_packet_deframer, bound to the top.
// Depends on gpd_pkg for field widths.
`timescale 1ns / 1ps

module gpd_checker (
  input logic                             clk_i,
  input logic                             rst_ni,
  input logic                             in_valid_i,
  input logic                             in_ready_o,
  input logic [gpd_pkg::ByteW-1:0]        rx_byte_i,
  input logic                             out_valid_o,
  input logic                             out_ready_i,
  input logic signed [gpd_pkg::WordW-1:0] rate_centi_o,
  input logic signed [gpd_pkg::WordW-1:0] angle_centi_o,
  input logic                             checksum_ok_o
);

  // a held result must not change
  a_out_hold: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && !out_ready_i |=> out_valid_o && $stable(rate_centi_o)
      && $stable(angle_centi_o) && $stable(checksum_ok_o))
    else $error("output changed while stalled");

  // an empty output register never blocks input
  a_ready_when_empty: assert property (@(posedge clk_i) disable iff (!rst_ni)
    !out_valid_o |-> in_ready_o)
    else $error("input stalled with empty output");

  // a new result only follows an accepted byte
  a_rise_needs_byte: assert property (@(posedge clk_i) disable iff (!rst_ni)
    $rose(out_valid_o) |-> $past(in_valid_i && in_ready_o))
    else $error("result without input transaction");

  // after an output transaction, valid stays only if a byte came in
  a_no_repeat: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && out_ready_i |=> !out_valid_o || $past(in_valid_i && in_ready_o))
    else $error("result repeated");

  logic unused_byte;
  assign unused_byte = ^rx_byte_i;

endmodule

bind gyro_packet_deframer gpd_checker u_gpd_checker (.*);
